// ===== rtl/rrpd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrpd_pkg
// Shared types and constants for the raw rectangle pixel decoder.
// ---------------------------------------------------------------------------
package rrpd_pkg;

   localparam int NumChan = 3;
   localparam int ChanRed = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue = 2;

   // configuration register indexes
   localparam logic [2:0] CsrPixelMode  = 3'd0;
   localparam logic [2:0] CsrRedShift   = 3'd1;
   localparam logic [2:0] CsrGreenShift = 3'd2;
   localparam logic [2:0] CsrBlueShift  = 3'd3;
   localparam logic [2:0] CsrRedMax     = 3'd4;
   localparam logic [2:0] CsrGreenMax   = 3'd5;
   localparam logic [2:0] CsrBlueMax    = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COUNT,
      PH_HEADER,
      PH_PIXELS
   } phase_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_DIVIDE,
      SC_HOLD
   } scale_state_type;

   typedef struct packed {
      logic                         pixel_mode;
      logic [NumChan-1:0][4:0]      shift;
      logic [NumChan-1:0][15:0]     max;
   } cfg_type;

   typedef struct packed {
      logic [31:0] word;
      logic [16:0] x;
      logic [16:0] y;
      logic        last;
   } job_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scale_status_type;

endpackage
`default_nettype wire

// ===== rtl/raw_rect_pixel_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// raw_rect_pixel_decoder
// Decodes raw rectangles of a framebuffer-update body into colored pixels.
// ---------------------------------------------------------------------------
// The parser takes one message byte per clock and places each complete pixel
// in a small job queue; it stalls (full) only while that queue is full.
// The color scaler takes one job at a time: it loads the job while idle,
// runs a restoring division (one quotient bit per cycle, all three channels
// side by side), then holds the result until popped, so it takes no new
// job before the last result is popped. With 2- or 4-byte pixels the byte
// rate is set by this divider once the queue has filled.
module raw_rect_pixel_decoder #(
   parameter int QueueDepth = 2
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_message_start,
   output logic        empty,
   input  wire         pop,
   output logic [16:0] rsp_pixel_x,
   output logic [16:0] rsp_pixel_y,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_in_update,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   rrpd_pkg::cfg_type          cfg_ff;
   rrpd_pkg::job_type          parse_job, head_job;
   rrpd_pkg::scale_status_type sc_status;
   logic                       job_push, job_take, q_full, q_empty, rsp_valid;
   logic [rrpd_pkg::NumChan-1:0][7:0] color;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_mode                 <= 1'b1;
         cfg_ff.shift[rrpd_pkg::ChanRed]   <= 5'd16;
         cfg_ff.shift[rrpd_pkg::ChanGreen] <= 5'd8;
         cfg_ff.shift[rrpd_pkg::ChanBlue]  <= 5'd0;
         cfg_ff.max                        <= {3{16'd255}};
      end else if (csr_we) begin
         unique case (csr_index)
            rrpd_pkg::CsrPixelMode:  cfg_ff.pixel_mode <= csr_wdata[0];
            rrpd_pkg::CsrRedShift:   cfg_ff.shift[rrpd_pkg::ChanRed] <= csr_wdata[4:0];
            rrpd_pkg::CsrGreenShift: cfg_ff.shift[rrpd_pkg::ChanGreen] <= csr_wdata[4:0];
            rrpd_pkg::CsrBlueShift:  cfg_ff.shift[rrpd_pkg::ChanBlue] <= csr_wdata[4:0];
            rrpd_pkg::CsrRedMax:     cfg_ff.max[rrpd_pkg::ChanRed] <= csr_wdata;
            rrpd_pkg::CsrGreenMax:   cfg_ff.max[rrpd_pkg::ChanGreen] <= csr_wdata;
            rrpd_pkg::CsrBlueMax:    cfg_ff.max[rrpd_pkg::ChanBlue] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign full = q_full;

   rrpd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (push && !q_full),
      .data_byte     (req_data_byte),
      .message_start (req_message_start),
      .pixel_mode    (cfg_ff.pixel_mode),
      .job_push      (job_push),
      .job           (parse_job)
   );

   rrpd_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (parse_job),
      .pop      (job_take),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rrpd_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_ready (!q_empty),
      .job       (head_job),
      .job_take  (job_take),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_x     (rsp_pixel_x),
      .rsp_y     (rsp_pixel_y),
      .rsp_color (color),
      .rsp_last  (rsp_last_in_update),
      .status    (sc_status)
   );

   assign empty     = !rsp_valid;
   assign rsp_red   = color[rrpd_pkg::ChanRed];
   assign rsp_green = color[rrpd_pkg::ChanGreen];
   assign rsp_blue  = color[rrpd_pkg::ChanBlue];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full) else $error("job pushed into full queue");

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !(sc_status.busy && sc_status.done)) else $error("scaler busy and done");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty) else $error("result visible after reset");

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |=> sc_status.busy) else $error("job taken but divider idle");

endmodule
`default_nettype wire

// ===== rtl/rrpd_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrpd_parser
// Front end: walks the message bytes and emits one job per complete pixel.
// ---------------------------------------------------------------------------
module rrpd_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   byte_valid,
   input  wire  [7:0]            data_byte,
   input  wire                   message_start,
   input  wire                   pixel_mode,
   output logic                  job_push,
   output rrpd_pkg::job_type     job
);

   rrpd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] rects_ff, rects_in;
   logic [15:0] rect_x_ff, rect_x_in, rect_y_ff, rect_y_in;
   logic [15:0] rect_w_ff, rect_w_in, rect_h_ff, rect_h_in;
   logic [15:0] col_ff, col_in, row_ff, row_in;
   logic [31:0] shreg_ff, shreg_in;
   logic [1:0]  pix_idx_ff, pix_idx_in;
   logic        last_col, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rrpd_pkg::PH_IDLE;
         hdr_idx_ff <= '0;
         rects_ff   <= '0;
         rect_x_ff  <= '0;
         rect_y_ff  <= '0;
         rect_w_ff  <= '0;
         rect_h_ff  <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         shreg_ff   <= '0;
         pix_idx_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         rects_ff   <= rects_in;
         rect_x_ff  <= rect_x_in;
         rect_y_ff  <= rect_y_in;
         rect_w_ff  <= rect_w_in;
         rect_h_ff  <= rect_h_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         shreg_ff   <= shreg_in;
         pix_idx_ff <= pix_idx_in;
      end
   end

   assign last_col = (col_ff + 16'd1) == rect_w_ff;
   assign last_row = (row_ff + 16'd1) == rect_h_ff;

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      rects_in   = rects_ff;
      rect_x_in  = rect_x_ff;
      rect_y_in  = rect_y_ff;
      rect_w_in  = rect_w_ff;
      rect_h_in  = rect_h_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      shreg_in   = shreg_ff;
      pix_idx_in = pix_idx_ff;
      job_push   = 1'b0;
      job.word   = pixel_mode ? shreg_ff : {16'd0, shreg_ff[15:0]};
      job.x      = {1'b0, rect_x_ff} + {1'b0, col_ff};
      job.y      = {1'b0, rect_y_ff} + {1'b0, row_ff};
      job.last   = last_col && last_row && (rects_ff == 16'd1);
      if (byte_valid && message_start) begin
         // restart on the padding byte
         phase_in   = rrpd_pkg::PH_COUNT;
         hdr_idx_in = '0;
         rects_in   = '0;
         shreg_in   = '0;
         pix_idx_in = '0;
      end else if (byte_valid) begin
         unique case (phase_ff)
            rrpd_pkg::PH_IDLE: begin
            end
            rrpd_pkg::PH_COUNT: begin
               rects_in = {rects_ff[7:0], data_byte};
               if (hdr_idx_ff == 4'd0) begin
                  hdr_idx_in = 4'd1;
               end else begin
                  hdr_idx_in = '0;
                  phase_in = (rects_in == 16'd0) ? rrpd_pkg::PH_IDLE
                                                 : rrpd_pkg::PH_HEADER;
               end
            end
            rrpd_pkg::PH_HEADER: begin
               unique case (hdr_idx_ff[3:1])
                  3'd0:    rect_x_in = {rect_x_ff[7:0], data_byte};
                  3'd1:    rect_y_in = {rect_y_ff[7:0], data_byte};
                  3'd2:    rect_w_in = {rect_w_ff[7:0], data_byte};
                  3'd3:    rect_h_in = {rect_h_ff[7:0], data_byte};
                  default: begin
                  end
               endcase
               if (hdr_idx_ff < 4'd11) begin
                  hdr_idx_in = hdr_idx_ff + 4'd1;
               end else if (rect_w_ff == 16'd0 || rect_h_ff == 16'd0) begin
                  // empty rectangle: move on
                  rects_in   = rects_ff - 16'd1;
                  hdr_idx_in = '0;
                  phase_in   = (rects_in == 16'd0) ? rrpd_pkg::PH_IDLE
                                                   : rrpd_pkg::PH_HEADER;
               end else begin
                  hdr_idx_in = '0;
                  col_in     = '0;
                  row_in     = '0;
                  shreg_in   = '0;
                  pix_idx_in = '0;
                  phase_in   = rrpd_pkg::PH_PIXELS;
               end
            end
            rrpd_pkg::PH_PIXELS: begin
               shreg_in = shreg_ff | ({24'd0, data_byte} << {pix_idx_ff, 3'b000});
               if (pix_idx_ff < (pixel_mode ? 2'd3 : 2'd1)) begin
                  pix_idx_in = pix_idx_ff + 2'd1;
               end else begin
                  job_push   = 1'b1;
                  job.word   = pixel_mode ? shreg_in : {16'd0, shreg_in[15:0]};
                  shreg_in   = '0;
                  pix_idx_in = '0;
                  if (!last_col) begin
                     col_in = col_ff + 16'd1;
                  end else begin
                     col_in = '0;
                     if (!last_row) begin
                        row_in = row_ff + 16'd1;
                     end else begin
                        row_in     = '0;
                        rects_in   = rects_ff - 16'd1;
                        hdr_idx_in = '0;
                        phase_in   = (rects_in == 16'd0) ? rrpd_pkg::PH_IDLE
                                                         : rrpd_pkg::PH_HEADER;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rrpd_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrpd_fifo
// Short job queue between the parser and the color scaler.
// ---------------------------------------------------------------------------
module rrpd_fifo #(
   parameter int Depth = 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  rrpd_pkg::job_type  push_job,
   input  wire                pop,
   output rrpd_pkg::job_type  head_job,
   output logic               full,
   output logic               empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   rrpd_pkg::job_type slot_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = count_ff == CW'(Depth);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rrpd_scaler.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrpd_scaler
// Back end: scales the three color fields with a shared-schedule restoring
// divider, one quotient bit per channel per cycle, and holds the result.
// ---------------------------------------------------------------------------
module rrpd_scaler (
   input  wire                        clock,
   input  wire                        reset,
   input  rrpd_pkg::cfg_type          cfg,
   input  wire                        job_ready,
   input  rrpd_pkg::job_type          job,
   output logic                       job_take,
   input  wire                        rsp_pop,
   output logic                       rsp_valid,
   output logic [16:0]                rsp_x,
   output logic [16:0]                rsp_y,
   output logic [rrpd_pkg::NumChan-1:0][7:0] rsp_color,
   output logic                       rsp_last,
   output rrpd_pkg::scale_status_type status
);

   rrpd_pkg::scale_state_type state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [16:0] x_ff, y_ff;
   logic        last_ff;
   logic [rrpd_pkg::NumChan-1:0][16:0] rem_ff;
   logic [rrpd_pkg::NumChan-1:0][16:0] div_ff;
   logic [rrpd_pkg::NumChan-1:0][7:0]  quo_ff;
   logic [rrpd_pkg::NumChan-1:0][17:0] rem_dbl;
   logic [rrpd_pkg::NumChan-1:0][31:0] shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrpd_pkg::SC_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      job_take = 1'b0;
      unique case (state_ff)
         rrpd_pkg::SC_IDLE: begin
            if (job_ready) begin
               job_take = 1'b1;
               step_in  = '0;
               state_in = rrpd_pkg::SC_DIVIDE;
            end
         end
         rrpd_pkg::SC_DIVIDE: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = rrpd_pkg::SC_HOLD;
            end
         end
         rrpd_pkg::SC_HOLD: begin
            if (rsp_pop) begin
               state_in = rrpd_pkg::SC_IDLE;
            end
         end
         default: state_in = rrpd_pkg::SC_IDLE;
      endcase
   end

   always_comb begin
      for (int c = 0; c < rrpd_pkg::NumChan; c++) begin
         shifted[c] = job.word >> cfg.shift[c];
         rem_dbl[c] = {rem_ff[c], 1'b0};
      end
   end

   // field < max + 1, so the quotient fits in 8 bits: start from the field
   always_ff @(posedge clock) begin
      if (job_take) begin
         x_ff    <= job.x;
         y_ff    <= job.y;
         last_ff <= job.last;
         for (int c = 0; c < rrpd_pkg::NumChan; c++) begin
            rem_ff[c] <= {1'b0, shifted[c][15:0] & cfg.max[c]};
            div_ff[c] <= {1'b0, cfg.max[c]} + 17'd1;
            quo_ff[c] <= '0;
         end
      end else if (state_ff == rrpd_pkg::SC_DIVIDE) begin
         for (int c = 0; c < rrpd_pkg::NumChan; c++) begin
            if (rem_dbl[c] >= {1'b0, div_ff[c]}) begin
               rem_ff[c] <= 17'(rem_dbl[c] - {1'b0, div_ff[c]});
               quo_ff[c] <= {quo_ff[c][6:0], 1'b1};
            end else begin
               rem_ff[c] <= rem_dbl[c][16:0];
               quo_ff[c] <= {quo_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   assign rsp_valid   = state_ff == rrpd_pkg::SC_HOLD;
   assign rsp_x       = x_ff;
   assign rsp_y       = y_ff;
   assign rsp_color   = quo_ff;
   assign rsp_last    = last_ff;
   assign status.busy = state_ff == rrpd_pkg::SC_DIVIDE;
   assign status.done = rsp_valid;

endmodule
`default_nettype wire

// ===== dv/tb_raw_rect_pixel_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_raw_rect_pixel_decoder
// Feeds framebuffer-update bodies byte by byte into the raw rectangle pixel
// decoder and checks every decoded pixel against an in-bench prediction of
// the parser and color scaler, under random stalls and several color setups.
// ---------------------------------------------------------------------------
module tb_raw_rect_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 30;
   localparam int LongHold      = 400;

   typedef struct {
      logic [7:0] data;
      logic       start;
   } body_byte_type;

   typedef struct {
      logic [16:0] x;
      logic [16:0] y;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic        last;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = '0;
   logic        req_message_start = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [16:0] rsp_pixel_x, rsp_pixel_y;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic        rsp_last_in_update;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   raw_rect_pixel_decoder dut (.*);

   always #2 clock = ~clock;

   body_byte_type byte_q[$];
   pixel_type     pixel_q[$];
   int         errors = 0;
   int         byte_count = 0;
   logic       in_taken = 1'b0;
   bit         tx_nogap = 1'b0;
   bit         rx_long_req = 1'b0;
   int         rx_long_cnt = 0;
   int         rx_gap = 0;
   int         tx_gap = 0;
   int         idle_cycles = 0;

   // decoder model state
   logic                si_mode_dummy_unused_guard;
   logic                m_mode;
   logic [4:0]          m_shift[rrpd_pkg::NumChan];
   logic [15:0]         m_max[rrpd_pkg::NumChan];
   rrpd_pkg::phase_type m_phase;
   logic [3:0]          m_hdr_idx;
   logic [15:0]         m_rects, m_x, m_y, m_w, m_h, m_col, m_row;
   logic [31:0]         m_word;
   logic [1:0]          m_byte_idx;

   function automatic logic [7:0] scale(logic [31:0] v, logic [4:0] sh, logic [15:0] mx);
      longint unsigned fld;
      fld = (v >> sh) & {16'h0, mx};
      return 8'((fld * 256) / (longint'(mx) + 1));
   endfunction

   task automatic end_rect();
      m_rects   = m_rects - 16'd1;
      m_hdr_idx = '0;
      m_phase   = (m_rects == 16'd0) ? rrpd_pkg::PH_IDLE : rrpd_pkg::PH_HEADER;
   endtask

   task automatic decode_byte(logic [7:0] b, logic st);
      int          last_idx;
      logic [31:0] v;
      bit          lc, lr;
      pixel_type   p;
      if (st) begin
         m_phase = rrpd_pkg::PH_COUNT; m_hdr_idx = '0; m_rects = '0;
         m_word = '0; m_byte_idx = '0;
         return;
      end
      case (m_phase)
         rrpd_pkg::PH_COUNT: begin
            m_rects = {m_rects[7:0], b};
            if (m_hdr_idx == 4'd0) begin
               m_hdr_idx = 4'd1;
            end else begin
               m_hdr_idx = '0;
               m_phase = (m_rects == 16'd0) ? rrpd_pkg::PH_IDLE : rrpd_pkg::PH_HEADER;
            end
         end
         rrpd_pkg::PH_HEADER: begin
            case (m_hdr_idx)
               0, 1: m_x = {m_x[7:0], b};
               2, 3: m_y = {m_y[7:0], b};
               4, 5: m_w = {m_w[7:0], b};
               6, 7: m_h = {m_h[7:0], b};
               default: ;
            endcase
            if (m_hdr_idx < 4'd11) begin
               m_hdr_idx = m_hdr_idx + 4'd1;
            end else if (m_w == 16'd0 || m_h == 16'd0) begin
               end_rect();
            end else begin
               m_hdr_idx = '0; m_col = '0; m_row = '0;
               m_word = '0; m_byte_idx = '0;
               m_phase = rrpd_pkg::PH_PIXELS;
            end
         end
         rrpd_pkg::PH_PIXELS: begin
            last_idx = m_mode ? 3 : 1;
            m_word = m_word | (32'(b) << (8 * m_byte_idx));
            if (int'(m_byte_idx) < last_idx) begin
               m_byte_idx = m_byte_idx + 2'd1;
               return;
            end
            v = m_mode ? m_word : {16'h0, m_word[15:0]};
            m_word = '0; m_byte_idx = '0;
            lc = (int'(m_col) + 1 == int'(m_w));
            lr = (int'(m_row) + 1 == int'(m_h));
            p.x = 17'(m_x) + 17'(m_col);
            p.y = 17'(m_y) + 17'(m_row);
            p.r = scale(v, m_shift[rrpd_pkg::ChanRed], m_max[rrpd_pkg::ChanRed]);
            p.g = scale(v, m_shift[rrpd_pkg::ChanGreen], m_max[rrpd_pkg::ChanGreen]);
            p.b = scale(v, m_shift[rrpd_pkg::ChanBlue], m_max[rrpd_pkg::ChanBlue]);
            p.last = lc && lr && m_rects == 16'd1;
            pixel_q.push_back(p);
            if (!lc) begin
               m_col = m_col + 16'd1;
            end else begin
               m_col = '0;
               if (!lr) begin
                  m_row = m_row + 16'd1;
               end else begin
                  m_row = '0;
                  end_rect();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      pixel_type e;
      in_taken <= push && !full;
      if (!reset) begin
         if (pop && !empty) begin
            if (pixel_q.size() == 0) begin
               report("unexpected pixel x", rsp_pixel_x, 0);
            end else begin
               e = pixel_q.pop_front();
               if (rsp_pixel_x !== e.x) report("pixel_x", rsp_pixel_x, e.x);
               if (rsp_pixel_y !== e.y) report("pixel_y", rsp_pixel_y, e.y);
               if (rsp_red !== e.r) report("red", rsp_red, e.r);
               if (rsp_green !== e.g) report("green", rsp_green, e.g);
               if (rsp_blue !== e.b) report("blue", rsp_blue, e.b);
               if (rsp_last_in_update !== e.last)
                  report("last_in_update", rsp_last_in_update, e.last);
            end
         end
         if (push && !full) decode_byte(req_data_byte, req_message_start);
         if ((pop && !empty) || (push && !full)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: hold the current transaction until taken, then advance
   always @(negedge clock) begin
      body_byte_type nb;
      if (!reset && (!push || in_taken)) begin
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            push <= 1'b0;
         end else if (byte_q.size() != 0) begin
            nb = byte_q.pop_front();
            req_data_byte <= nb.data;
            req_message_start <= nb.start;
            push <= 1'b1;
            tx_gap <= tx_nogap ? 0 : pick_gap();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rx_long_req && rx_long_cnt < LongHold) begin
         rx_long_cnt <= rx_long_cnt + 1;
         pop <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         pop <= 1'b0;
      end else if (tx_nogap || $urandom_range(0, 99) < 70) begin
         pop <= 1'b1;
      end else begin
         pop <= 1'b0;
         rx_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                : $urandom_range(10, 40);
      end
   end

   task automatic put(logic [7:0] b, logic st = 1'b0);
      body_byte_type t;
      t.data = b; t.start = st;
      byte_q.push_back(t);
      byte_count++;
   endtask

   task automatic put_head(logic [15:0] count);
      put(8'($urandom), 1'b1);
      put(count[15:8]); put(count[7:0]);
   endtask

   task automatic put_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic [15:0] h);
      int n;
      put(x[15:8]); put(x[7:0]); put(y[15:8]); put(y[7:0]);
      put(w[15:8]); put(w[7:0]); put(h[15:8]); put(h[7:0]);
      repeat (4) put(8'($urandom));
      n = int'(w) * int'(h) * (m_mode ? 4 : 2);
      repeat (n) put(8'($urandom));
   endtask

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 3) == 0) return 16'hFFFF - 16'($urandom_range(0, 3));
      return 16'($urandom);
   endfunction

   task automatic put_update(int nrects, int maxdim);
      put_head(16'(nrects));
      repeat (nrects)
         put_rect(pick_coord(), pick_coord(), 16'($urandom_range(0, maxdim)),
                  16'($urandom_range(0, maxdim)));
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      case (idx)
         rrpd_pkg::CsrPixelMode:  m_mode = val[0];
         rrpd_pkg::CsrRedShift:   m_shift[rrpd_pkg::ChanRed] = val[4:0];
         rrpd_pkg::CsrGreenShift: m_shift[rrpd_pkg::ChanGreen] = val[4:0];
         rrpd_pkg::CsrBlueShift:  m_shift[rrpd_pkg::ChanBlue] = val[4:0];
         rrpd_pkg::CsrRedMax:     m_max[rrpd_pkg::ChanRed] = val;
         rrpd_pkg::CsrGreenMax:   m_max[rrpd_pkg::ChanGreen] = val;
         rrpd_pkg::CsrBlueMax:    m_max[rrpd_pkg::ChanBlue] = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic setup(logic mode, logic [4:0] rs, logic [4:0] gs, logic [4:0] bs,
                        logic [15:0] rm, logic [15:0] gm, logic [15:0] bm);
      csr_write(rrpd_pkg::CsrPixelMode, 16'(mode));
      csr_write(rrpd_pkg::CsrRedShift, 16'(rs));
      csr_write(rrpd_pkg::CsrGreenShift, 16'(gs));
      csr_write(rrpd_pkg::CsrBlueShift, 16'(bs));
      csr_write(rrpd_pkg::CsrRedMax, rm);
      csr_write(rrpd_pkg::CsrGreenMax, gm);
      csr_write(rrpd_pkg::CsrBlueMax, bm);
   endtask

   function automatic logic [15:0] pick_max();
      case ($urandom_range(0, 4))
         0: return 16'h0;
         1: return 16'hFFFF;
         2: return 16'((32'h1 << $urandom_range(1, 16)) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   // wait until the sender and the block have drained
   task automatic drain();
      while (byte_q.size() != 0 || push || pixel_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      int cut, r;
      m_mode = 1'b1;
      m_shift[rrpd_pkg::ChanRed] = 5'd16;
      m_shift[rrpd_pkg::ChanGreen] = 5'd8;
      m_shift[rrpd_pkg::ChanBlue] = 5'd0;
      m_max[rrpd_pkg::ChanRed] = 16'd255;
      m_max[rrpd_pkg::ChanGreen] = 16'd255;
      m_max[rrpd_pkg::ChanBlue] = 16'd255;
      m_phase = rrpd_pkg::PH_IDLE; m_hdr_idx = '0; m_rects = '0;
      m_x = '0; m_y = '0; m_w = '0; m_h = '0; m_col = '0; m_row = '0;
      m_word = '0; m_byte_idx = '0;
      si_mode_dummy_unused_guard = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset setup, stray bytes, zero count, edge coordinates,
      // empty last rectangle, restart in the middle of a rectangle
      put(8'hFF); put(8'h00);
      put_head(16'd0);
      put_head(16'd2);
      put_rect(16'hFFFF, 16'hFFFF, 16'd2, 16'd2);
      put_rect(16'd5, 16'd6, 16'd0, 16'd3);
      put_head(16'd1);
      put_rect(16'd0, 16'd0, 16'd1, 16'd1);
      put_head(16'd3);
      put(8'h00); put(8'h10);
      put_head(16'd1);
      put_rect(16'd7, 16'd9, 16'd1, 16'd1);
      drain();

      // pixel mode flipped in the middle of a pixel, then flipped back
      put_head(16'd1);
      put(8'h00); put(8'h01); put(8'h00); put(8'h02);
      put(8'h00); put(8'h01); put(8'h00); put(8'h02);
      repeat (4) put(8'h00);
      put(8'hA5); put(8'h5A); put(8'hC3);
      drain();
      csr_write(rrpd_pkg::CsrPixelMode, 16'd0);
      put(8'h3C); put(8'h81);
      put(8'hE7);
      drain();
      csr_write(rrpd_pkg::CsrPixelMode, 16'd1);
      put(8'h11); put(8'h22); put(8'h33);
      drain();

      // extremes of the color setup
      setup(1'b0, 5'd31, 5'd31, 5'd31, 16'hFFFF, 16'h0, 16'hFFFF);
      put_update(2, 3);
      drain();
      setup(1'b1, 5'd0, 5'd31, 5'd4, 16'h0, 16'hFFFF, 16'h1);
      put_update(2, 3);
      drain();
      setup(1'b0, 5'd0, 5'd5, 5'd11, 16'd31, 16'd63, 16'd31);
      put_update(2, 3);
      drain();

      // long receiver hold while the sender keeps offering pixels
      tx_nogap = 1'b1;
      rx_long_req = 1'b1;
      put_update(1, 6);
      put_head(16'd1);
      put_rect(16'd100, 16'd200, 16'd8, 16'd8);
      drain();
      tx_nogap = 1'b0;

      while (byte_count < 2000) begin
         setup(1'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
               pick_max(), pick_max(), pick_max());
         tx_nogap = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               put_update($urandom_range(0, 3), 4);
            end else if (r < 90) begin
               // broken update: keep only a prefix
               cut = byte_q.size();
               put_update($urandom_range(1, 3), 4);
               cut = cut + $urandom_range(1, byte_q.size() - cut);
               while (byte_q.size() > cut) begin
                  void'(byte_q.pop_back());
                  byte_count--;
               end
            end else begin
               repeat ($urandom_range(1, 6)) put(8'($urandom));
            end
         end
         drain();
      end
      tx_nogap = 1'b0;

      drain();
      if (errors == 0 && !si_mode_dummy_unused_guard) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rrpd_pkg.sv
rtl/rrpd_parser.sv
rtl/rrpd_fifo.sv
rtl/rrpd_scaler.sv
rtl/raw_rect_pixel_decoder.sv
dv/tb_raw_rect_pixel_decoder.sv
